@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Implication helpers for concurrent checks, same cycle and next cycle.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/mcw_pkg.sv @@
// ----------------------------------------------------------------------------
// mcw_pkg
// Sizes, command and status codes, sequencer states of the watchdog.
// ----------------------------------------------------------------------------
package mcw_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int TIMEOUT_BITS = 24;
  localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(NUM_CHANNELS - 1);

  localparam int CMD_W     = 3;
  localparam int CHAN_W    = 4;
  localparam int TMO_IN_W  = 24;
  localparam int STATUS_W  = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_START      = 3'd1,
    CMD_STOP       = 3'd2,
    CMD_REGISTER   = 3'd3,
    CMD_UNREGISTER = 3'd4,
    CMD_ENTER      = 3'd5,
    CMD_EXIT       = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_FIRED        = 3'd1,
    ST_ALREADY_REG  = 3'd2,
    ST_ALREADY_BUSY = 3'd3,
    ST_DISABLED     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_FLUSH,
    S_ENTER_WR,
    S_DONE
  } state_t;

endpackage

@@ hdl/multi_channel_watchdog.sv @@
// ----------------------------------------------------------------------------
// multi_channel_watchdog
// Per-channel watchdog; tick and start sweep the remaining-count memory.
// ----------------------------------------------------------------------------
// Steps: tick and start run EXEC, SWEEP (one remaining-count memory access per
//   channel), FLUSH, DONE; enter runs EXEC, ENTER_WR, DONE; others EXEC, DONE.
// in_tready is low while busy: a new beat waits until the last result is registered.
// Reset: synchronous active-low rst_n clears monitor, registered and busy
//   flags and the output valid; the count memories need no clearing pass.
module multi_channel_watchdog
  import mcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [3:0] channel, [27:4] timeout_ms, [31:28] zero
  input  logic [CMD_W-1:0]      in_tuser,   // [2:0] cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [2:0] status, [6:3] fired_channel, [7] running
);

  state_t state_r, state_nxt;

  logic [CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [IDX_W-1:0]        chan_r, chan_nxt;
  logic                    ok_r, ok_nxt;
  logic [TIMEOUT_BITS-1:0] tmo_r, tmo_nxt;

  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             proc_vld_r, proc_vld_nxt;
  logic [IDX_W-1:0] proc_idx_r, proc_idx_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] who_r, who_nxt;
  status_t          stat_r, stat_nxt;
  logic             mon_r, mon_nxt;

  logic [NUM_CHANNELS-1:0] reg_r, reg_nxt;
  logic [NUM_CHANNELS-1:0] busy_r, busy_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [TIMEOUT_BITS-1:0] rem_mem [NUM_CHANNELS];
  logic [TIMEOUT_BITS-1:0] tmo_mem [NUM_CHANNELS];
  logic [TIMEOUT_BITS-1:0] rem_rd_r, tmo_rd_r;
  logic                    rem_we, tmo_we;
  logic [IDX_W-1:0]        rem_waddr;
  logic [TIMEOUT_BITS-1:0] rem_wdata;

  logic                    in_fire;
  logic                    dec;
  logic                    hit;
  logic [TIMEOUT_BITS-1:0] new_rem;
  logic                    fire_en;
  logic [CHAN_W-1:0]       fired_ch;
  logic                    res_fired;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign res_fired  = out_valid_r && (out_data_r[2:0] == ST_FIRED);

  // count memories
  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    rem_rd_r <= rem_mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (tmo_we) begin
      tmo_mem[chan_r] <= tmo_r;
    end
    tmo_rd_r <= tmo_mem[chan_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mon_r       <= 1'b0;
      reg_r       <= '0;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
      proc_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mon_r       <= mon_nxt;
      reg_r       <= reg_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      proc_vld_r  <= proc_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    chan_r     <= chan_nxt;
    ok_r       <= ok_nxt;
    tmo_r      <= tmo_nxt;
    cnt_r      <= cnt_nxt;
    proc_idx_r <= proc_idx_nxt;
    found_r    <= found_nxt;
    who_r      <= who_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

  // one channel of the sweep: saturating decrement and expiry check
  always_comb begin
    dec     = (cmd_r == CMD_TICK) && busy_r[proc_idx_r] && (rem_rd_r != '0);
    new_rem = dec ? (rem_rd_r - TIMEOUT_BITS'(1)) : rem_rd_r;
    hit     = proc_vld_r && busy_r[proc_idx_r] && (new_rem == '0);
    fire_en = (cmd_r == CMD_START) || mon_r;
    fired_ch = (stat_r == ST_FIRED) ? CHAN_W'(who_r) : '0;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    chan_nxt      = chan_r;
    ok_nxt        = ok_r;
    tmo_nxt       = tmo_r;
    cnt_nxt       = cnt_r;
    proc_vld_nxt  = proc_vld_r;
    proc_idx_nxt  = proc_idx_r;
    found_nxt     = found_r;
    who_nxt       = who_r;
    stat_nxt      = stat_r;
    mon_nxt       = mon_r;
    reg_nxt       = reg_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    rem_we        = 1'b0;
    rem_waddr     = proc_idx_r;
    rem_wdata     = new_rem;
    tmo_we        = 1'b0;

    if ((state_r == S_SWEEP || state_r == S_FLUSH) && proc_vld_r) begin
      rem_we = dec;
      if (hit && !found_r) begin
        found_nxt = 1'b1;
        who_nxt   = proc_idx_r;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_tuser;
          chan_nxt  = IDX_W'(in_tdata[CHAN_W-1:0]);
          ok_nxt    = (32'(in_tdata[CHAN_W-1:0]) < NUM_CHANNELS);
          tmo_nxt   = TIMEOUT_BITS'(in_tdata[CHAN_W +: TMO_IN_W]);
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        stat_nxt     = ST_OK;
        who_nxt      = '0;
        found_nxt    = 1'b0;
        cnt_nxt      = '0;
        proc_vld_nxt = 1'b0;
        state_nxt    = S_DONE;
        case (cmd_r)
          CMD_TICK, CMD_START: begin
            state_nxt = S_SWEEP;
          end
          CMD_STOP: begin
            reg_nxt  = '0;
            busy_nxt = '0;
            mon_nxt  = 1'b0;
          end
          CMD_REGISTER: begin
            if (ok_r) begin
              if (tmo_r == '0) begin
                stat_nxt = ST_DISABLED;
              end else if (reg_r[chan_r]) begin
                stat_nxt = ST_ALREADY_REG;
              end else begin
                reg_nxt[chan_r] = 1'b1;
                tmo_we          = 1'b1;
              end
            end
          end
          CMD_UNREGISTER: begin
            if (ok_r) begin
              reg_nxt[chan_r]  = 1'b0;
              busy_nxt[chan_r] = 1'b0;
            end
          end
          CMD_ENTER: begin
            if (ok_r && reg_r[chan_r]) begin
              if (busy_r[chan_r]) begin
                stat_nxt = ST_ALREADY_BUSY;
              end else begin
                state_nxt = S_ENTER_WR;
              end
            end
          end
          CMD_EXIT: begin
            if (ok_r) begin
              busy_nxt[chan_r] = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      S_SWEEP: begin
        proc_vld_nxt = 1'b1;
        proc_idx_nxt = cnt_r;
        if (cnt_r == LAST_CH) begin
          state_nxt = S_FLUSH;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_FLUSH: begin
        proc_vld_nxt = 1'b0;
        if (cmd_r == CMD_START) begin
          mon_nxt = 1'b1;
        end
        if (fire_en && (found_r || hit)) begin
          stat_nxt = ST_FIRED;
          mon_nxt  = 1'b0;
        end
        state_nxt = S_DONE;
      end
      S_ENTER_WR: begin
        rem_we           = 1'b1;
        rem_waddr        = chan_r;
        rem_wdata        = tmo_rd_r;
        busy_nxt[chan_r] = 1'b1;
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {mon_r, fired_ch, stat_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`include "assert_macros.svh"

  `ASSERT_IMP(a_busy_needs_reg, clk, rst_n, 1'b1, (busy_r & ~reg_r) == '0)
  `ASSERT_NXT(a_accept_blocks, clk, rst_n, in_fire, !in_tready)
  `ASSERT_IMP(a_fired_stops, clk, rst_n, res_fired, !out_data_r[7])
  `ASSERT_IMP(a_fired_ch_zero, clk, rst_n, out_valid_r && !res_fired, out_data_r[6:3] == '0)

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for multi_channel_watchdog. An initial block queues a
// short directed sequence, then random register/enter/start/tick sessions
// mixed with noise commands. A clocked driver feeds the input stream with
// random idle cycles. A cycle-free predictor computes the result of every
// accepted beat. A clocked monitor applies random backpressure and checks
// each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import mcw_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int N_ITEMS = 1100;
  localparam int CALM_LO = 6000;
  localparam int CALM_HI = 12000;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [CHAN_W-1:0]   chan;
    logic [TMO_IN_W-1:0] tmo;
  } wd_cmd_t;

  typedef struct {
    status_t           status;
    logic [CHAN_W-1:0] fired;
    logic              running;
  } wd_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [3:0] channel, [27:4] timeout_ms, [31:28] zero
  logic [CMD_W-1:0]      in_tuser = '0;   // [2:0] cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [2:0] status, [6:3] fired_channel, [7] running

  wd_cmd_t    cmd_backlog[$];
  wd_result_t due_results[$];
  wd_cmd_t    drv_beat;
  wd_result_t mon_due;
  int         accepted_count = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;

  // predictor state
  logic                    wd_on;
  logic                    wd_reg [NUM_CHANNELS];
  logic                    wd_busy[NUM_CHANNELS];
  logic [TIMEOUT_BITS-1:0] wd_tmo [NUM_CHANNELS];
  logic [TIMEOUT_BITS-1:0] wd_rem [NUM_CHANNELS];

  multi_channel_watchdog u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic void clear_channels();
    for (int n = 0; n < NUM_CHANNELS; n++) begin
      wd_reg[n]  = 1'b0;
      wd_busy[n] = 1'b0;
      wd_tmo[n]  = '0;
      wd_rem[n]  = '0;
    end
  endfunction

  // lowest busy channel at zero, or -1
  function automatic int expired_channel();
    for (int n = 0; n < NUM_CHANNELS; n++) begin
      if (wd_busy[n] && wd_rem[n] == '0) return n;
    end
    return -1;
  endfunction

  function automatic wd_result_t watchdog_step(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] chan,
                                               logic [TMO_IN_W-1:0] tmo_in);
    wd_result_t              r;
    logic [TIMEOUT_BITS-1:0] tmo;
    bit                      ok;
    int                      c;
    int                      who;
    r.status  = ST_OK;
    r.fired   = '0;
    tmo       = TIMEOUT_BITS'(tmo_in);
    ok        = int'(chan) < NUM_CHANNELS;
    c         = ok ? int'(chan) : 0;
    case (cmd)
      CMD_TICK: begin
        for (int n = 0; n < NUM_CHANNELS; n++) begin
          if (wd_busy[n] && wd_rem[n] != '0) wd_rem[n] = wd_rem[n] - 1'b1;
        end
        if (wd_on) begin
          who = expired_channel();
          if (who >= 0) begin
            r.status = ST_FIRED;
            r.fired  = CHAN_W'(who);
            wd_on    = 1'b0;
          end
        end
      end
      CMD_START: begin
        wd_on = 1'b1;
        who = expired_channel();
        if (who >= 0) begin
          r.status = ST_FIRED;
          r.fired  = CHAN_W'(who);
          wd_on    = 1'b0;
        end
      end
      CMD_STOP: begin
        clear_channels();
        wd_on = 1'b0;
      end
      CMD_REGISTER: begin
        if (ok) begin
          if (tmo == '0) r.status = ST_DISABLED;
          else if (wd_reg[c]) r.status = ST_ALREADY_REG;
          else begin
            wd_reg[c] = 1'b1;
            wd_tmo[c] = tmo;
          end
        end
      end
      CMD_UNREGISTER: begin
        if (ok) begin
          wd_reg[c]  = 1'b0;
          wd_busy[c] = 1'b0;
          wd_tmo[c]  = '0;
          wd_rem[c]  = '0;
        end
      end
      CMD_ENTER: begin
        if (ok && wd_reg[c]) begin
          if (wd_busy[c]) r.status = ST_ALREADY_BUSY;
          else begin
            wd_busy[c] = 1'b1;
            wd_rem[c]  = wd_tmo[c];
          end
        end
      end
      CMD_EXIT: begin
        if (ok) begin
          wd_busy[c] = 1'b0;
          wd_rem[c]  = '0;
        end
      end
      default: ;
    endcase
    r.running = wd_on;
    return r;
  endfunction

  task automatic report(input string msg);
    if (mismatch_count < 50) $display("mismatch @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int chan, input logic [31:0] tmo);
    wd_cmd_t b;
    b.cmd  = cmd;
    b.chan = CHAN_W'(chan);
    b.tmo  = TMO_IN_W'(tmo);
    cmd_backlog.push_back(b);
  endtask

  function automatic logic [31:0] pick_timeout();
    int r;
    r = $urandom_range(9);
    case (r)
      0:       return 32'd0;
      1:       return $urandom;
      2:       return ($urandom_range(1) != 0) ? 32'hFFFFFF : (32'd1 << $urandom_range(23));
      default: return $urandom_range(6, 1);
    endcase
  endfunction

  // register a few channels, enter them, start and tick, then tear down a bit
  task automatic queue_session();
    int n;
    int ch[4];
    n = $urandom_range(4, 1);
    for (int k = 0; k < n; k++) begin
      ch[k] = $urandom_range(15);
      queue_cmd(CMD_REGISTER, ch[k], pick_timeout());
    end
    for (int k = 0; k < n; k++) begin
      queue_cmd(CMD_ENTER, ch[k], $urandom);
      if ($urandom_range(9) == 0) queue_cmd(CMD_ENTER, ch[k], $urandom);
    end
    queue_cmd(CMD_START, $urandom_range(15), $urandom);
    repeat ($urandom_range(8)) queue_cmd(CMD_TICK, $urandom_range(15), $urandom);
    case ($urandom_range(3))
      0:       queue_cmd(CMD_STOP, $urandom_range(15), $urandom);
      1:       queue_cmd(CMD_EXIT, ch[$urandom_range(n - 1)], $urandom);
      2:       queue_cmd(CMD_UNREGISTER, ch[$urandom_range(n - 1)], $urandom);
      default: ;
    endcase
  endtask

  // driver: predict on accept, then load the next beat unless idling
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(watchdog_step(in_tuser, in_tdata[3:0], in_tdata[27:4]));
        accepted_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_backlog.size() > 0 &&
            ((cycle_count >= CALM_LO && cycle_count < CALM_HI) || $urandom_range(99) >= 16)) begin
          drv_beat = cmd_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0, drv_beat.tmo, drv_beat.chan};
          in_tuser  <= drv_beat.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: backpressure and result check
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          report($sformatf("result beat with nothing pending: %h", out_tdata));
        end else begin
          mon_due = due_results.pop_front();
          if (out_tdata[2:0] != mon_due.status)
            report($sformatf("status %0d, want %0d", out_tdata[2:0], mon_due.status));
          if (out_tdata[6:3] != mon_due.fired)
            report($sformatf("fired_channel %0d, want %0d", out_tdata[6:3], mon_due.fired));
          if (out_tdata[7] != mon_due.running)
            report($sformatf("running %0d, want %0d", out_tdata[7], mon_due.running));
        end
      end
      out_tready <= (cycle_count >= CALM_LO && cycle_count < CALM_HI) ||
                    $urandom_range(99) >= 16;
    end
  end

  initial begin
    int total;
    wd_on = 1'b0;
    clear_channels();

    queue_cmd(CMD_REGISTER, 0, 1);
    queue_cmd(CMD_REGISTER, 15, 32'hFFFFFF);
    queue_cmd(CMD_REGISTER, 3, 0);            // zero timeout
    queue_cmd(CMD_REGISTER, 0, 5);            // double registration
    queue_cmd(CMD_ENTER, 0, 0);
    queue_cmd(CMD_ENTER, 0, 0);               // double entry
    queue_cmd(CMD_ENTER, 5, 0);               // not registered
    queue_cmd(CMD_EXIT, 7, 0);                // already idle
    queue_cmd(CMD_ENTER, 15, 32'hFFFFFF);
    queue_cmd(CMD_START, 0, 0);
    queue_cmd(CMD_TICK, 0, 0);                // ch0 runs out
    queue_cmd(CMD_TICK, 15, 32'hFFFFFF);      // stopped, counts still drop
    queue_cmd(CMD_UNUSED, 15, 32'hFFFFFF);
    queue_cmd(CMD_START, 0, 0);               // fires at once
    queue_cmd(CMD_EXIT, 0, 0);
    queue_cmd(CMD_UNREGISTER, 15, 0);
    queue_cmd(CMD_ENTER, 15, 0);
    queue_cmd(CMD_REGISTER, 2, 2);
    queue_cmd(CMD_REGISTER, 1, 2);
    queue_cmd(CMD_ENTER, 2, 0);
    queue_cmd(CMD_ENTER, 1, 0);
    queue_cmd(CMD_START, 9, 32'h555555);
    queue_cmd(CMD_TICK, 6, 32'hAAAAAA);
    queue_cmd(CMD_TICK, 0, 0);                // tie, lowest channel wins
    queue_cmd(CMD_STOP, 0, 0);

    while (cmd_backlog.size() < N_ITEMS) begin
      if ($urandom_range(4) == 0)
        queue_cmd(CMD_W'($urandom_range(7)), $urandom_range(15), $urandom);
      else
        queue_session();
    end
    total = cmd_backlog.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (NUM_CHANNELS + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS multi_channel_watchdog");
    end else begin
      $display("FAIL multi_channel_watchdog");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAIL multi_channel_watchdog");
    $finish;
  end

endmodule
